@@ rtl/core/pcds_pkg.sv @@
// Package for the pixel clock divider search.
// Constants and types shared by the stage module and the top level.
package pcds_pkg;
   localparam int unsigned FreqWidth = 20;
   localparam int unsigned FracMin   = 18;
   localparam int unsigned FracMax   = 35;
   localparam int unsigned NumFrac   = FracMax - FracMin + 1;
   localparam logic [31:0] PllHz     = 32'd480000000;
   localparam logic [9:0]  KScale    = 10'd1000;
   localparam logic [9:0]  LowStart  = 10'd999;
   localparam logic [7:0]  NoFrac    = 8'd255;
   localparam logic        StatusOk  = 1'b0;
   localparam logic        StatusZero = 1'b1;

   typedef struct packed {
      logic [9:0] low_rest;
      logic [7:0] low_x;
      logic [7:0] low_k;
      logic [9:0] high_rest;
      logic [7:0] high_x;
      logic [7:0] high_k;
   } best_type;
endpackage

@@ rtl/core/pcds_div.sv @@
// Restoring divider stage: one quotient bit per stage, pipelined 32 deep.
// Uses pcds_pkg. Computes 480000000 / freq for one item per cycle while advance is high.
module pcds_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [pcds_pkg::FreqWidth-1:0]   in_freq,
   output logic                             out_valid,
   output logic [pcds_pkg::FreqWidth-1:0]   out_freq,
   output logic [31:0]                      out_quot
);
   import pcds_pkg::*;

   logic [32:0]          valid_ff;
   logic [FreqWidth-1:0] freq_ff  [33];
   logic [31:0]          quot_ff  [33];
   logic [FreqWidth:0]   rem_ff   [33];
   logic [31:0]          quot_in  [32];
   logic [FreqWidth:0]   rem_in   [32];

   always_comb begin
      for (int i = 0; i < 32; i++) begin
         logic [FreqWidth+1:0] trial;
         trial = {rem_ff[i], PllHz[31-i]};
         quot_in[i] = quot_ff[i];
         if (trial >= {2'b00, freq_ff[i]}) begin
            rem_in[i] = (FreqWidth+1)'(trial - {2'b00, freq_ff[i]});
            quot_in[i][31-i] = 1'b1;
         end else begin
            rem_in[i] = trial[FreqWidth:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[31:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         freq_ff[0] <= in_freq;
         quot_ff[0] <= '0;
         rem_ff[0]  <= '0;
         for (int i = 0; i < 32; i++) begin
            freq_ff[i+1] <= freq_ff[i];
            quot_ff[i+1] <= quot_in[i];
            rem_ff[i+1]  <= rem_in[i];
         end
      end
   end

   assign out_valid = valid_ff[32];
   assign out_freq  = freq_ff[32];
   assign out_quot  = quot_ff[32];
endmodule

@@ rtl/core/pixel_clock_divider_search.sv @@
// Top level of the pixel clock divider search.
// Uses pcds_pkg and pcds_div.
// One item per cycle. Registered steps, in order: the divider, fp and the per-candidate
// quotients, the k and remainder split, the partial and the final selection, and the
// output. The whole pipe halts while a result waits unaccepted at the output.
module pixel_clock_divider_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // freq_khz[19:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status[0], frac_value[8:1], pixel_div[16:9]
);
   import pcds_pkg::*;

   logic advance;
   logic dv;
   logic [FreqWidth-1:0] dfreq;
   logic [31:0] dquot;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   pcds_div u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_tvalid), .in_freq(req_tdata[FreqWidth-1:0]),
      .out_valid(dv), .out_freq(dfreq), .out_quot(dquot));

   // stage A: fp and tk = fp / x per candidate (constant divisors)
   // fp at or above 2^24 gives k above 255 for every x, so 24 bits of fp suffice
   logic        a_valid_ff;
   logic        a_zero_ff;
   logic        a_big_ff;
   logic [19:0] tk_ff [NumFrac];
   logic [19:0] tk_in [NumFrac];
   logic [31:0] fp;
   assign fp = 32'(dquot * 32'd18);

   for (genvar i = 0; i < NumFrac; i++) begin : g_tk
      localparam logic [25:0] Recip =
         26'(((64'd1 << 30) + 64'(FracMin + i) - 64'd1) / 64'(FracMin + i));
      logic [49:0] prod;
      assign prod     = {26'd0, fp[23:0]} * {24'd0, Recip};
      assign tk_in[i] = prod[49:30];
   end

   // stage B: k and remainder per candidate
   localparam logic [20:0] KRecip =
      21'(((64'd1 << 30) + 64'(KScale) - 64'd1) / 64'(KScale));
   logic        b_valid_ff;
   logic        b_zero_ff;
   logic [NumFrac-1:0] ok_ff;
   logic [9:0]  rest_ff [NumFrac];
   logic [7:0]  k_ff    [NumFrac];
   logic [9:0]  kq_in   [NumFrac];
   logic [9:0]  rest_in [NumFrac];

   always_comb begin
      for (int i = 0; i < NumFrac; i++) begin
         kq_in[i]   = 10'(({21'd0, tk_ff[i]} * {20'd0, KRecip}) >> 30);
         rest_in[i] = 10'(tk_ff[i] - 20'(kq_in[i] * {10'd0, KScale}));
      end
   end

   // stage C: partial selection over groups of 6
   localparam int unsigned Grp = 3;
   localparam int unsigned GrpSize = NumFrac / Grp;
   logic     c_valid_ff;
   logic     c_zero_ff;
   best_type part_ff [Grp];
   best_type part_in [Grp];

   // stage D: final best
   logic     d_valid_ff;
   logic     d_zero_ff;
   best_type best_ff;
   best_type best_in;

   function automatic best_type merge(best_type acc, logic ok, logic [9:0] r,
                                      logic [7:0] x, logic [7:0] k);
      best_type res;
      res = acc;
      if (ok && r < acc.low_rest) begin
         res.low_rest = r; res.low_x = x; res.low_k = k;
      end
      if (ok && r > acc.high_rest) begin
         res.high_rest = r; res.high_x = x; res.high_k = k;
      end
      return res;
   endfunction

   function automatic best_type combine(best_type a, best_type b);
      best_type res;
      res = a;
      if (b.low_rest < a.low_rest) begin
         res.low_rest = b.low_rest; res.low_x = b.low_x; res.low_k = b.low_k;
      end
      if (b.high_rest > a.high_rest) begin
         res.high_rest = b.high_rest; res.high_x = b.high_x; res.high_k = b.high_k;
      end
      return res;
   endfunction

   localparam best_type Init = '{low_rest: LowStart, low_x: NoFrac, low_k: 8'd0,
                                 high_rest: 10'd0, high_x: NoFrac, high_k: 8'd0};

   always_comb begin
      for (int g = 0; g < Grp; g++) begin
         part_in[g] = Init;
         for (int j = 0; j < GrpSize; j++) begin
            part_in[g] = merge(part_in[g], ok_ff[g*GrpSize+j], rest_ff[g*GrpSize+j],
                               8'(FracMin + g*GrpSize + j), k_ff[g*GrpSize+j]);
         end
      end
      best_in = combine(combine(part_ff[0], part_ff[1]), part_ff[2]);
   end

   logic        out_valid_ff;
   logic [16:0] out_data_ff;
   logic [16:0] out_data_in;
   logic [10:0] high_gap;

   always_comb begin
      high_gap = 11'(KScale) - {1'b0, best_ff.high_rest};
      if (d_zero_ff) begin
         out_data_in = {8'd0, 8'd0, StatusZero};
      end else if (high_gap > {1'b0, best_ff.low_rest}) begin
         out_data_in = {best_ff.low_k, best_ff.low_x, StatusOk};
      end else begin
         out_data_in = {best_ff.high_k, best_ff.high_x, StatusOk};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= dv;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_zero_ff <= (dfreq == '0);
         a_big_ff  <= (fp[31:24] != 8'd0);
         for (int i = 0; i < NumFrac; i++) begin
            tk_ff[i] <= tk_in[i];
         end
         b_zero_ff <= a_zero_ff;
         for (int i = 0; i < NumFrac; i++) begin
            ok_ff[i]   <= !a_big_ff && (kq_in[i] != 10'd0) && (kq_in[i] <= 10'd255);
            rest_ff[i] <= rest_in[i];
            k_ff[i]    <= kq_in[i][7:0];
         end
         c_zero_ff   <= b_zero_ff;
         part_ff     <= part_in;
         d_zero_ff   <= c_zero_ff;
         best_ff     <= best_in;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[16:1] == 16'd0)
      else $error("zero request gave nonzero dividers");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] && rsp_tdata[8:1] != NoFrac |->
      rsp_tdata[8:1] >= 8'(FracMin) && rsp_tdata[8:1] <= 8'(FracMax)
      && rsp_tdata[16:9] != 8'd0)
      else $error("chosen divider out of range");
endmodule
